### hdl/utf8_to_ucs2_decoder_unit_defines.svh
// Assertion macros for the decoder unit's checker file.
`ifndef UTF8_TO_UCS2_DECODER_UNIT_DEFINES_SVH
`define UTF8_TO_UCS2_DECODER_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define AST_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/utd_pkg.sv
// Shared types, constants and byte classification for the UTF-8 to UCS-2 decoder.
package utd_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned UNIT_W  = 16;
	localparam int unsigned MAX_RES = 3;
	localparam int unsigned CNT_W   = 2;

	// Byte classes
	typedef enum logic [2:0] {
		CLS_ASCII = 3'd0,
		CLS_CONT  = 3'd1,
		CLS_LEAD2 = 3'd2,
		CLS_LEAD3 = 3'd3,
		CLS_BAD   = 3'd4
	} utd_cls_t;

	// Sequence lengths held in the expected length register
	localparam logic [1:0] LEN_NONE = 2'd0;
	localparam logic [1:0] LEN_TWO  = 2'd2;
	localparam logic [1:0] LEN_THREE = 2'd3;

	// Results of one request, in emission order from slot 0
	typedef struct packed {
		logic [MAX_RES-1:0][UNIT_W-1:0] units;
		logic [CNT_W-1:0]               cnt;
	} utd_grp_t;

	// Classify a byte by its leading bits
	function automatic utd_cls_t classify(input logic [BYTE_W-1:0] b);
		utd_cls_t c;
		case (b) inside
			[8'h00:8'h7F]: c = CLS_ASCII;
			[8'h80:8'hBF]: c = CLS_CONT;
			[8'hC0:8'hDF]: c = CLS_LEAD2;
			[8'hE0:8'hEF]: c = CLS_LEAD3;
			default:       c = CLS_BAD;
		endcase
		return c;
	endfunction

endpackage

### hdl/utd_decode.sv
// Input register, sequence state and single-pass decode of one byte into a result group.
module utd_decode
	import utd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              in_eot,
	output logic              grp_valid,
	input  logic              grp_ready,
	output utd_grp_t          grp
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              eot_s1;

	logic [1:0]        pc_q;
	logic [1:0]        el_q;
	logic [BYTE_W-1:0] p0_q;
	logic [BYTE_W-1:0] p1_q;

	logic [1:0]        nxt_pc;
	logic [1:0]        nxt_el;
	logic [BYTE_W-1:0] nxt_p0;
	logic [BYTE_W-1:0] nxt_p1;
	logic              do_fresh;
	utd_cls_t          cls;
	utd_grp_t          g;
	logic              adv;

	// Append one unit to a group; a full group stays as it is
	function automatic utd_grp_t push(input utd_grp_t gi, input logic [UNIT_W-1:0] u);
		utd_grp_t go;
		go = gi;
		case (gi.cnt)
			2'd0: begin
				go.units[0] = u;
				go.cnt      = 2'd1;
			end
			2'd1: begin
				go.units[1] = u;
				go.cnt      = 2'd2;
			end
			2'd2: begin
				go.units[2] = u;
				go.cnt      = 2'd3;
			end
			default: go = gi;
		endcase
		return go;
	endfunction

	assign adv       = valid_s1 && grp_ready;
	assign in_ready  = !valid_s1 || grp_ready;
	assign grp_valid = valid_s1;
	assign grp       = g;

	// Hold the accepted byte until the result stage takes its group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			eot_s1  <= in_eot;
		end
	end

	// Decode: flush on interruption, start or complete a sequence, flush on end of text
	always_comb begin
		g        = '0;
		cls      = classify(byte_s1);
		nxt_pc   = pc_q;
		nxt_el   = el_q;
		nxt_p0   = p0_q;
		nxt_p1   = p1_q;
		do_fresh = 1'b0;

		if (pc_q == 2'd0) begin
			do_fresh = 1'b1;
		end else if (cls == CLS_CONT) begin
			if ((pc_q + 2'd1) >= el_q) begin
				if (el_q == LEN_THREE) begin
					g = push(g, {p0_q[3:0], p1_q[5:0], byte_s1[5:0]});
				end else begin
					g = push(g, {5'd0, p0_q[4:0], byte_s1[5:0]});
				end
				nxt_pc = 2'd0;
				nxt_el = LEN_NONE;
			end else begin
				nxt_p1 = byte_s1;
				nxt_pc = 2'd2;
			end
		end else begin
			g = push(g, {8'd0, p0_q});
			if (pc_q == 2'd2) begin
				g = push(g, {8'd0, p1_q});
			end
			nxt_pc   = 2'd0;
			nxt_el   = LEN_NONE;
			do_fresh = 1'b1;
		end

		if (do_fresh) begin
			if (cls == CLS_LEAD2) begin
				nxt_p0 = byte_s1;
				nxt_pc = 2'd1;
				nxt_el = LEN_TWO;
			end else if (cls == CLS_LEAD3) begin
				nxt_p0 = byte_s1;
				nxt_pc = 2'd1;
				nxt_el = LEN_THREE;
			end else begin
				g = push(g, {8'd0, byte_s1});
			end
		end

		if (eot_s1) begin
			if (nxt_pc != 2'd0) begin
				g = push(g, {8'd0, nxt_p0});
			end
			if (nxt_pc == 2'd2) begin
				g = push(g, {8'd0, nxt_p1});
			end
			nxt_pc = 2'd0;
			nxt_el = LEN_NONE;
		end
	end

	// Advance the sequence state with each decoded byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= 2'd0;
			el_q <= LEN_NONE;
		end else if (adv) begin
			pc_q <= nxt_pc;
			el_q <= nxt_el;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p0_q <= nxt_p0;
			p1_q <= nxt_p1;
		end
	end

endmodule

### hdl/utd_emit.sv
// Result register: holds one group, hands out a unit per cycle while out_ready is high.
module utd_emit
	import utd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              grp_valid,
	output logic              grp_ready,
	input  utd_grp_t          grp,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [UNIT_W-1:0] out_unit,
	output logic              out_last
);

	logic [MAX_RES-1:0][UNIT_W-1:0] units_q;
	logic [CNT_W-1:0]               cnt_q;
	logic                           take;
	logic                           load;

	assign out_valid = cnt_q != '0;
	assign out_unit  = units_q[0];
	assign out_last  = cnt_q == 2'd1;
	assign take      = out_valid && out_ready;
	assign grp_ready = (cnt_q == '0) || (out_last && out_ready);
	assign load      = grp_valid && grp_ready;

	// Count remaining units: reload on a new group, drop one per accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= grp.cnt;
		end else if (take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Shift the next unit into the head slot
	always_ff @(posedge clk) begin
		if (load) begin
			units_q <= grp.units;
		end else if (take) begin
			units_q <= {{UNIT_W{1'b0}}, units_q[MAX_RES-1:1]};
		end
	end

endmodule

### hdl/utf8_to_ucs2_decoder_unit.sv
// UTF-8 to UCS-2 decoder: top level joining the decode stage and the result register.
//
// Input stream (s_*): one UTF-8 byte per request in s_tdata[7:0]; s_tlast marks the
// last byte of a text and flushes any pending lead or continuation bytes raw.
// Output stream (m_*): one 16-bit code unit per request in m_tdata[15:0]; m_tlast is
// high on the last unit caused by one input byte. A byte may cause zero to three units.
// Path: an accepted byte is held in the input register and then decoded into the result
// register, which then offers the first unit of the byte on m_tvalid.
// Throughput: one byte per cycle while each byte yields at most one unit and m_tready
// is high; a byte with more units holds the result register until its last unit goes,
// as the single output port moves one unit per cycle; a byte with none leaves it empty.
// Reset (arst_n low) empties both stages and drops any pending sequence.
// When the receiver stalls, the result register holds its unit, the input register
// fills, and s_tready falls until the output moves again; nothing is lost.
module utf8_to_ucs2_decoder_unit
	import utd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [BYTE_W-1:0] s_tdata,   // [7:0] in_byte
	input  logic              s_tlast,   // end_of_text
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [UNIT_W-1:0] m_tdata,   // [15:0] code_unit
	output logic              m_tlast    // run_last
);

	utd_grp_t grp;
	logic     grp_valid;
	logic     grp_ready;

	// Decode each byte against the held sequence
	utd_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.in_eot    (s_tlast),
		.grp_valid (grp_valid),
		.grp_ready (grp_ready),
		.grp       (grp)
	);

	// Serialize each result group onto the output stream
	utd_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp_valid (grp_valid),
		.grp_ready (grp_ready),
		.grp       (grp),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_unit  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule

### hdl/utd_checker.sv
// Port-level checker for the decoder unit and its bind to the top level.
`include "utf8_to_ucs2_decoder_unit_defines.svh"

module utd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tlast
);

	// An empty result register always leaves room for a new byte
	`AST_SAME(a_idle_ready, !m_tvalid, s_tready, "input stalled while output is empty")

	// A decoded unit above the byte range ends its run
	`AST_SAME(a_wide_last, m_tvalid && (m_tdata[15:8] != 8'h00), m_tlast, "wide unit not last of run")

	// Units of one run follow without a gap
	`AST_NEXT(a_run_cont, m_tvalid && m_tready && !m_tlast, m_tvalid, "gap inside a run")

	// A stalled unit holds
	`AST_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled unit changed")

endmodule

bind utf8_to_ucs2_decoder_unit utd_checker u_utd_checker (.*);

### sim/tb_top.sv
// Testbench for the UTF-8 to UCS-2 decoder unit: random bursts in, random stalls out.
`timescale 1ns / 100ps

module tb_top;
	import utd_pkg::*;

	// Random stimulus kinds
	localparam int KIND_ASCII  = 0;
	localparam int KIND_TWO    = 1;
	localparam int KIND_THREE  = 2;
	localparam int KIND_NOISE  = 3;
	localparam int KIND_BROKEN = 4;
	localparam int KIND_HIGH   = 5;

	// Receiver stall modes
	localparam int RX_FREE = 0;
	localparam int RX_COIN = 1;
	localparam int RX_SLOW = 2;

	localparam int RANDOM_BYTES = 125;
	localparam int HOLD_AT      = 60;
	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_LIMIT  = 2000;

	typedef struct packed {
		logic [BYTE_W-1:0] b;
		logic              eot;
	} text_byte_t;

	typedef struct packed {
		logic [UNIT_W-1:0] unit;
		logic              last;
	} unit_rec_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [BYTE_W-1:0] s_tdata = '0;   // [7:0] in_byte
	logic              s_tlast = 1'b0; // end_of_text
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [UNIT_W-1:0] m_tdata;        // [15:0] code_unit
	logic              m_tlast;        // run_last

	text_byte_t        text_q[$];
	text_byte_t        next_byte;
	unit_rec_t         units_due[$];
	unit_rec_t         head_unit;
	logic [UNIT_W-1:0] step_units[$];

	// Decoder image: sequence in progress
	logic [1:0]        seq_cnt = 2'd0;
	logic [1:0]        seq_len = LEN_NONE;
	logic [BYTE_W-1:0] seq_bytes [2];

	int  fails = 0;
	int  bytes_taken = 0;
	bit  byte_taken = 1'b0;
	int  burst_left = 0;
	int  gap_left = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	int  rx_mode = RX_FREE;
	int  mode_left = 0;

	utf8_to_ucs2_decoder_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic utd_cls_t byte_kind(input logic [BYTE_W-1:0] b);
		if (b < 8'h80)
			return CLS_ASCII;
		if (b < 8'hC0)
			return CLS_CONT;
		if (b < 8'hE0)
			return CLS_LEAD2;
		if (b < 8'hF0)
			return CLS_LEAD3;
		return CLS_BAD;
	endfunction

	// Queue one raw or decoded unit for the current byte
	function automatic void add_unit(input logic [UNIT_W-1:0] u);
		step_units.insert(step_units.size(), u);
	endfunction

	// Start a sequence on a lead byte, else pass the byte through raw
	function automatic void open_or_pass(input logic [BYTE_W-1:0] b);
		case (byte_kind(b))
			CLS_LEAD2: begin
				seq_bytes[0] = b;
				seq_cnt = 2'd1;
				seq_len = LEN_TWO;
			end
			CLS_LEAD3: begin
				seq_bytes[0] = b;
				seq_cnt = 2'd1;
				seq_len = LEN_THREE;
			end
			default: add_unit({8'h00, b});
		endcase
	endfunction

	// Emit held bytes raw in arrival order and drop the sequence
	function automatic void flush_seq();
		for (int i = 0; i < seq_cnt; i++)
			add_unit({8'h00, seq_bytes[i]});
		seq_cnt = 2'd0;
		seq_len = LEN_NONE;
	endfunction

	// Work out the code units caused by one accepted byte
	function automatic void decode_byte(input logic [BYTE_W-1:0] b, input logic eot);
		logic [31:0] v;
		step_units.delete();
		if (seq_cnt == 2'd0) begin
			open_or_pass(b);
		end else if (byte_kind(b) == CLS_CONT) begin
			if (seq_len == LEN_TWO || seq_cnt == 2'd2) begin
				if (seq_len == LEN_THREE)
					v = ({27'd0, seq_bytes[0][4:0]} << 12) | ({26'd0, seq_bytes[1][5:0]} << 6)
						| {26'd0, b[5:0]};
				else
					v = ({27'd0, seq_bytes[0][4:0]} << 6) | {26'd0, b[5:0]};
				add_unit(v[UNIT_W-1:0]);
				seq_cnt = 2'd0;
				seq_len = LEN_NONE;
			end else begin
				seq_bytes[1] = b;
				seq_cnt = 2'd2;
			end
		end else begin
			flush_seq();
			open_or_pass(b);
		end
		if (eot)
			flush_seq();
		foreach (step_units[i])
			units_due.insert(units_due.size(),
				unit_rec_t'{unit: step_units[i], last: (i == step_units.size() - 1)});
	endfunction

	function automatic void add_item(input logic [BYTE_W-1:0] b, input logic eot);
		text_q.insert(text_q.size(), text_byte_t'{b: b, eot: eot});
	endfunction

	// Draw a random byte from a range
	function automatic logic [BYTE_W-1:0] rand_byte(input int unsigned lo, input int unsigned hi);
		return BYTE_W'($urandom_range(lo, hi));
	endfunction

	// Append a byte with an occasional end of text
	function automatic void add_byte(input logic [BYTE_W-1:0] b);
		add_item(b, $urandom_range(0, 11) == 0);
	endfunction

	// Fill the byte queue, release reset, then wait for the drain
	initial begin
		int kind;
		int drain;
		logic [BYTE_W-1:0] b;

		// Directed: extremes, good sequences, stray and bad bytes, breaks, end of text
		add_item(8'h00, 1'b0);
		add_item(8'h7F, 1'b0);
		add_item(8'h80, 1'b0);
		add_item(8'hBF, 1'b0);
		add_item(8'hF0, 1'b0);
		add_item(8'hFF, 1'b0);
		add_item(8'hC0, 1'b0);
		add_item(8'h80, 1'b0);
		add_item(8'hDF, 1'b0);
		add_item(8'hBF, 1'b0);
		add_item(8'hEF, 1'b0);
		add_item(8'hBF, 1'b0);
		add_item(8'hBF, 1'b0);
		add_item(8'hC3, 1'b0);
		add_item(8'h41, 1'b0);
		add_item(8'hE2, 1'b0);
		add_item(8'h82, 1'b0);
		add_item(8'hC5, 1'b1);
		add_item(8'hE0, 1'b1);
		add_item(8'hE1, 1'b0);
		add_item(8'h80, 1'b1);
		add_item(8'hE2, 1'b0);
		add_item(8'hF5, 1'b0);
		add_item(8'h41, 1'b1);
		add_item(8'h9C, 1'b1);

		// Random: mostly well-formed sequences, some noise and broken ones
		while (text_q.size() < 25 + RANDOM_BYTES) begin
			kind = $urandom_range(0, 9);
			if (kind <= 2)
				kind = KIND_ASCII;
			else if (kind <= 4)
				kind = KIND_TWO;
			else if (kind <= 6)
				kind = KIND_THREE;
			else if (kind == 7)
				kind = KIND_NOISE;
			else if (kind == 8)
				kind = KIND_BROKEN;
			else
				kind = KIND_HIGH;
			case (kind)
				KIND_ASCII: add_byte(rand_byte(8'h00, 8'h7F));
				KIND_TWO: begin
					add_byte(rand_byte(8'hC0, 8'hDF));
					add_byte(rand_byte(8'h80, 8'hBF));
				end
				KIND_THREE: begin
					add_byte(rand_byte(8'hE0, 8'hEF));
					add_byte(rand_byte(8'h80, 8'hBF));
					add_byte(rand_byte(8'h80, 8'hBF));
				end
				KIND_NOISE: add_byte(rand_byte(8'h00, 8'hFF));
				KIND_BROKEN: begin
					add_byte(rand_byte(8'hC0, 8'hEF));
					if ($urandom_range(0, 1))
						add_byte(rand_byte(8'h80, 8'hBF));
					b = rand_byte(8'h00, 8'hFF);
					if (byte_kind(b) == CLS_CONT)
						b = b ^ 8'h40;
					add_byte(b);
				end
				default: add_byte(rand_byte(8'h80, 8'hFF));
			endcase
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for every byte to go in, then for the results to drain
		while (text_q.size() != 0 || s_tvalid)
			@(posedge clk);
		drain = 0;
		while (units_due.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (10) @(posedge clk);
		if (units_due.size() != 0) begin
			$error("%0d expected code units never arrived", units_due.size());
			fails++;
		end

		if (fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#400000;
		$display("Test completed with failures");
		$finish;
	end

	// Offer bytes in bursts; hold a request until it is taken
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || byte_taken)) begin
			byte_taken = 1'b0;
			if (gap_left > 0 || text_q.size() == 0) begin
				if (gap_left > 0)
					gap_left--;
				s_tvalid <= 1'b0;
			end else begin
				next_byte = text_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= next_byte.b;
				s_tlast <= next_byte.eot;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
				end
			end
		end
	end

	// Stall the output on a pattern of its own, with one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!hold_done && bytes_taken >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				m_tready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					rx_mode = $urandom_range(RX_FREE, RX_SLOW);
					mode_left = $urandom_range(5, 30);
				end else begin
					mode_left--;
				end
				case (rx_mode)
					RX_FREE: m_tready <= 1'b1;
					RX_COIN: m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Predict on each taken byte, check each taken code unit
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				decode_byte(s_tdata, s_tlast);
				byte_taken = 1'b1;
				bytes_taken++;
			end
			if (m_tvalid && m_tready) begin
				if (units_due.size() == 0) begin
					$error("unexpected result: code_unit %h run_last %b", m_tdata, m_tlast);
					fails++;
				end else begin
					head_unit = units_due.pop_front();
					if (m_tdata !== head_unit.unit) begin
						$error("code_unit mismatch: expected %h, got %h", head_unit.unit, m_tdata);
						fails++;
					end
					if (m_tlast !== head_unit.last) begin
						$error("run_last mismatch: expected %b, got %b", head_unit.last, m_tlast);
						fails++;
					end
				end
			end
		end
	end

endmodule

### sim.f
+incdir+hdl
hdl/utd_pkg.sv
hdl/utd_decode.sv
hdl/utd_emit.sv
hdl/utf8_to_ucs2_decoder_unit.sv
hdl/utd_checker.sv
sim/tb_top.sv
